FILE: src/esd_pkg.sv
// Shared types, constants and helper functions for the event subframe decoder.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

	// Sensor and subframe geometry
	localparam int SENSOR_WIDTH  = 1280;
	localparam int SENSOR_HEIGHT = 720;
	localparam int SUB_WIDTH     = 640;
	localparam int SUB_HEIGHT    = 360;
	localparam int PAD_WORDS     = 0;

	// Word layout
	localparam int WORD_W    = 64;
	localparam int LANES     = 32;
	localparam int LIDX_W    = $clog2(LANES);
	localparam int CODE_W    = 2;
	localparam int WPR       = SUB_WIDTH / LANES;
	localparam int TS_LSB    = 24;
	localparam int TS_W      = 40;
	localparam int SYNC_W    = 24;
	localparam logic [SYNC_W-1:0] SYNC_PATTERN = 24'h00FFFF;
	localparam int IDX_LSB   = 44;
	localparam int IDX_W     = 4;
	localparam logic [IDX_W-1:0] IDX_RIGHT = 4'd1;
	localparam logic [IDX_W-1:0] IDX_DOWN  = 4'd2;
	localparam logic [IDX_W-1:0] IDX_BOTH  = 4'd3;

	// Counter and coordinate widths
	localparam int CW   = (WPR > 1) ? $clog2(WPR) : 1;
	localparam int RW   = (SUB_HEIGHT > 1) ? $clog2(SUB_HEIGHT) : 1;
	localparam int PADW = (PAD_WORDS > 0) ? $clog2(PAD_WORDS + 1) : 1;
	localparam int XW   = $clog2(2 * SUB_WIDTH + SENSOR_WIDTH + 1);
	localparam int YW   = $clog2(2 * SUB_HEIGHT + SENSOR_HEIGHT + 1);
	localparam int XO_W = 11;
	localparam int YO_W = 10;
	localparam int COL_SHIFT = LIDX_W + 1;

	// Timestamp scaling
	localparam int TIME_DIV   = 200;
	localparam int REM_W      = $clog2(TIME_DIV);
	localparam int DIV_BITS   = 8;
	localparam int DIV_STAGES = TS_W / DIV_BITS;
	localparam int TQ_W       = 33;

	// Result queue
	localparam int Q_DEPTH = 16;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int RES_W   = $clog2(Q_DEPTH + 1);

	// Position within a subframe
	typedef enum logic [1:0] {
		POS_HDR,
		POS_SUB,
		POS_PIX,
		POS_PAD
	} pos_t;

	// Decoded word, front end to divider and merge
	typedef struct packed {
		logic             is_hdr;
		logic             err;
		logic [LANES-1:0] hit;
		logic [LANES-1:0] pol;
		logic [XW-1:0]    xbase;
		logic [YW-1:0]    y;
	} dec_t;

	// Long division state
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [TS_W-1:0]  num;
	} div_st_t;

	// Result queue entry
	typedef struct packed {
		logic             kind;
		logic [LANES-1:0] hit;
		logic [LANES-1:0] pol;
		logic [XW-1:0]    xbase;
		logic [YW-1:0]    y;
		logic [TQ_W-1:0]  tim;
	} q_ent_t;

	// DIV_BITS restoring steps: quotient bits shift into num as dividend bits leave
	function automatic div_st_t div_step(div_st_t a);
		div_st_t          r;
		logic [REM_W:0]   t;
		r = a;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, r.num[TS_W-1]};
			r.num = {r.num[TS_W-2:0], 1'b0};
			if (t >= (REM_W+1)'(TIME_DIV)) begin
				t = t - (REM_W+1)'(TIME_DIV);
				r.num[0] = 1'b1;
			end
			r.rem = t[REM_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/esd_lane.sv
// One pixel lane: bounds check and code test for a single 2-bit pixel.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_lane (
	input  wire logic [esd_pkg::CODE_W-1:0] code,
	input  wire logic [esd_pkg::XW-1:0]     x,
	input  wire logic                       row_ok,
	output logic                            hit,
	output logic                            pol
);

	logic col_ok;

	// inside the sensor and a nonzero code
	assign col_ok = x < esd_pkg::XW'(esd_pkg::SENSOR_WIDTH);
	assign hit    = col_ok && row_ok && (code != '0);
	assign pol    = code[1];

endmodule

`default_nettype wire

FILE: src/esd_front.sv
// Front end: subframe position tracking, header/subframe decode and the 32 pixel lanes.
// Depends on esd_pkg and esd_lane.
`timescale 1ns / 1ps
`default_nettype none

module esd_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       acc,
	input  wire logic [esd_pkg::WORD_W-1:0] word,
	input  wire logic                       start,
	output logic                            vld_s1,
	output esd_pkg::dec_t                   dec_s1,
	output logic [esd_pkg::TS_W-1:0]        ts_s1
);

	esd_pkg::pos_t              pos_q, pos_n, pos_eff;
	logic [esd_pkg::RW-1:0]     row_q, row_n, row_eff;
	logic [esd_pkg::CW-1:0]     col_q, col_n, col_eff;
	logic [esd_pkg::PADW-1:0]   pad_q, pad_n;
	logic                       offx_q, offx_n, offy_q, offy_n;
	logic [esd_pkg::RW:0]       row_inc;
	logic [esd_pkg::CW:0]       col_inc;
	logic [esd_pkg::PADW:0]     pad_inc;
	logic [esd_pkg::IDX_W-1:0]  sub_idx;
	logic [esd_pkg::XW-1:0]     xbase;
	logic [esd_pkg::YW-1:0]     ycur;
	logic                       row_ok;
	logic [esd_pkg::LANES-1:0]  lane_hit, lane_pol;
	esd_pkg::dec_t              dec;

	// chunk start forces header interpretation and clears the row and column counters
	assign pos_eff = start ? esd_pkg::POS_HDR : pos_q;
	assign row_eff = start ? '0 : row_q;
	assign col_eff = start ? '0 : col_q;
	assign row_inc = {1'b0, row_eff} + 1'b1;
	assign col_inc = {1'b0, col_eff} + 1'b1;
	assign pad_inc = {1'b0, pad_q} + 1'b1;
	assign sub_idx = word[esd_pkg::IDX_LSB +: esd_pkg::IDX_W];

	// next position and counters
	always_comb begin
		pos_n  = pos_eff;
		row_n  = row_eff;
		col_n  = col_eff;
		pad_n  = pad_q;
		offx_n = offx_q;
		offy_n = offy_q;
		unique case (pos_eff)
			esd_pkg::POS_HDR: begin
				pos_n = esd_pkg::POS_SUB;
			end
			esd_pkg::POS_SUB: begin
				offx_n = (sub_idx == esd_pkg::IDX_RIGHT) || (sub_idx == esd_pkg::IDX_BOTH);
				offy_n = (sub_idx == esd_pkg::IDX_DOWN) || (sub_idx == esd_pkg::IDX_BOTH);
				row_n  = '0;
				col_n  = '0;
				pos_n  = esd_pkg::POS_PIX;
			end
			esd_pkg::POS_PIX: begin
				col_n = col_inc[esd_pkg::CW-1:0];
				if (col_inc >= (esd_pkg::CW+1)'(esd_pkg::WPR)) begin
					col_n = '0;
					row_n = row_inc[esd_pkg::RW-1:0];
					if (row_inc >= (esd_pkg::RW+1)'(esd_pkg::SUB_HEIGHT)) begin
						row_n = '0;
						pad_n = '0;
						pos_n = (esd_pkg::PAD_WORDS > 0) ? esd_pkg::POS_PAD
						                                  : esd_pkg::POS_HDR;
					end
				end
			end
			esd_pkg::POS_PAD: begin
				if (pad_inc >= (esd_pkg::PADW+1)'(esd_pkg::PAD_WORDS)) begin
					pos_n = esd_pkg::POS_HDR;
				end else begin
					pad_n = pad_inc[esd_pkg::PADW-1:0];
				end
			end
			default: pos_n = esd_pkg::POS_HDR;
		endcase
	end

	// pixel coordinates of lane 0
	assign xbase  = esd_pkg::XW'({col_eff, {esd_pkg::COL_SHIFT{1'b0}}})
	              + esd_pkg::XW'(offx_q);
	assign ycur   = esd_pkg::YW'({row_eff, 1'b0}) + esd_pkg::YW'(offy_q);
	assign row_ok = ycur < esd_pkg::YW'(esd_pkg::SENSOR_HEIGHT);

	// one lane per pixel of the word
	for (genvar k = 0; k < esd_pkg::LANES; k++) begin : g_lane
		esd_lane u_lane (
			.code   (word[esd_pkg::CODE_W*k +: esd_pkg::CODE_W]),
			.x      (esd_pkg::XW'(xbase + esd_pkg::XW'(2 * k))),
			.row_ok (row_ok),
			.hit    (lane_hit[k]),
			.pol    (lane_pol[k])
		);
	end

	// decoded outputs
	always_comb begin
		dec.is_hdr = (pos_eff == esd_pkg::POS_HDR);
		dec.err    = dec.is_hdr && (word[esd_pkg::SYNC_W-1:0] != esd_pkg::SYNC_PATTERN);
		dec.hit    = (pos_eff == esd_pkg::POS_PIX) ? lane_hit : '0;
		dec.pol    = lane_pol;
		dec.xbase  = xbase;
		dec.y      = ycur;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= esd_pkg::POS_HDR;
			row_q  <= '0;
			col_q  <= '0;
			pad_q  <= '0;
			offx_q <= 1'b0;
			offy_q <= 1'b0;
		end else if (acc) begin
			pos_q  <= pos_n;
			row_q  <= row_n;
			col_q  <= col_n;
			pad_q  <= pad_n;
			offx_q <= offx_n;
			offy_q <= offy_n;
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dec_s1 <= dec;
			ts_s1  <= word[esd_pkg::TS_LSB +: esd_pkg::TS_W];
		end
	end

endmodule

`default_nettype wire

FILE: src/esd_tdiv.sv
// Timestamp divide-by-200 pipeline, 8 quotient bits per stage; carries the decoded word along.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_tdiv (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_vld,
	input  wire esd_pkg::dec_t           in_dec,
	input  wire logic [esd_pkg::TS_W-1:0] in_ts,
	output logic                         out_vld,
	output esd_pkg::dec_t                out_dec,
	output logic [esd_pkg::TQ_W-1:0]     out_quot
);

	logic              vld_s [esd_pkg::DIV_STAGES];
	esd_pkg::dec_t     dec_s [esd_pkg::DIV_STAGES];
	esd_pkg::div_st_t  st_s  [esd_pkg::DIV_STAGES];
	esd_pkg::div_st_t  st_in;

	assign st_in.rem = '0;
	assign st_in.num = in_ts;

	for (genvar g = 0; g < esd_pkg::DIV_STAGES; g++) begin : g_stage
		// stage valid and payload: one block of long-division steps
		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else begin
					vld_s[g] <= in_vld;
				end
			end

			always_ff @(posedge clk) begin
				dec_s[g] <= in_dec;
				st_s[g]  <= esd_pkg::div_step(st_in);
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else begin
					vld_s[g] <= vld_s[g-1];
				end
			end

			always_ff @(posedge clk) begin
				dec_s[g] <= dec_s[g-1];
				st_s[g]  <= esd_pkg::div_step(st_s[g-1]);
			end
		end
	end

	assign out_vld  = vld_s[esd_pkg::DIV_STAGES-1];
	assign out_dec  = dec_s[esd_pkg::DIV_STAGES-1];
	assign out_quot = st_s[esd_pkg::DIV_STAGES-1].num[esd_pkg::TQ_W-1:0];

endmodule

`default_nettype wire

FILE: src/esd_merge.sv
// Merge stage: timestamp register, result queue and the serializer that turns lane hits
// into one result beat per cycle while the output is not stalled. Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_merge (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       take,
	output logic                            room,
	input  wire logic                       d_vld,
	input  wire esd_pkg::dec_t              d_dec,
	input  wire logic [esd_pkg::TQ_W-1:0]   d_quot,
	output logic                            out_vld,
	input  wire logic                       out_rdy,
	output logic                            out_kind,
	output logic [esd_pkg::XO_W-1:0]        out_x,
	output logic [esd_pkg::YO_W-1:0]        out_y,
	output logic                            out_pol,
	output logic [esd_pkg::TQ_W-1:0]        out_time,
	output logic                            out_last
);

	logic [esd_pkg::TQ_W-1:0]   stime_q;
	esd_pkg::q_ent_t            qmem_q [esd_pkg::Q_DEPTH];
	esd_pkg::q_ent_t            ent;
	logic [esd_pkg::Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [esd_pkg::RES_W-1:0]  cnt_q, res_q;
	esd_pkg::q_ent_t            cur_q;
	logic                       cur_vld_q;
	logic                       push, drop, pop, adv, emit, done;
	logic [esd_pkg::LANES-1:0]  rest;
	logic [esd_pkg::LIDX_W-1:0] lo_idx;
	logic [esd_pkg::XW-1:0]     ex;

	// build queue entry; header timestamp bypasses the register
	always_comb begin
		ent.kind  = d_dec.err;
		ent.hit   = d_dec.hit;
		ent.pol   = d_dec.pol;
		ent.xbase = d_dec.xbase;
		ent.y     = d_dec.y;
		ent.tim   = d_dec.is_hdr ? d_quot : stime_q;
	end

	assign push = d_vld && (d_dec.err || (d_dec.hit != '0));
	assign drop = d_vld && !push;

	// serializer: lowest remaining hit goes out first
	always_comb begin
		lo_idx = '0;
		for (int i = esd_pkg::LANES - 1; i >= 0; i--) begin
			if (cur_q.hit[i]) begin
				lo_idx = esd_pkg::LIDX_W'(i);
			end
		end
	end

	assign rest = cur_q.hit & (cur_q.hit - 1'b1);
	assign done = cur_q.kind || (rest == '0);
	assign adv  = !out_vld || out_rdy;
	assign emit = cur_vld_q && adv;
	assign pop  = (cnt_q != '0) && (!cur_vld_q || (emit && done));
	assign ex   = esd_pkg::XW'(cur_q.xbase + esd_pkg::XW'({lo_idx, 1'b0}));

	// reservations cover queue plus words still in flight
	assign room = res_q < esd_pkg::RES_W'(esd_pkg::Q_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stime_q   <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
			res_q     <= '0;
			cur_vld_q <= 1'b0;
			out_vld   <= 1'b0;
		end else begin
			if (d_vld && d_dec.is_hdr) begin
				stime_q <= d_quot;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + esd_pkg::RES_W'(push) - esd_pkg::RES_W'(pop);
			res_q <= res_q + esd_pkg::RES_W'(take) - esd_pkg::RES_W'(pop)
			       - esd_pkg::RES_W'(drop);
			if (pop) begin
				cur_vld_q <= 1'b1;
			end else if (emit && done) begin
				cur_vld_q <= 1'b0;
			end
			if (emit) begin
				out_vld <= 1'b1;
			end else if (out_rdy) begin
				out_vld <= 1'b0;
			end
		end
	end

	// queue storage and current entry
	always_ff @(posedge clk) begin
		if (push) begin
			qmem_q[wr_ptr_q] <= ent;
		end
		if (pop) begin
			cur_q <= qmem_q[rd_ptr_q];
		end else if (emit) begin
			cur_q.hit <= rest;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind <= cur_q.kind;
			out_x    <= cur_q.kind ? '0 : esd_pkg::XO_W'(ex);
			out_y    <= cur_q.kind ? '0 : esd_pkg::YO_W'(cur_q.y);
			out_pol  <= cur_q.kind ? 1'b0 : cur_q.pol[lo_idx];
			out_time <= cur_q.tim;
			out_last <= done;
		end
	end

endmodule

`default_nettype wire

FILE: src/event_subframe_decoder_core.sv
// Top level of the event subframe decoder: front end, timestamp divider and merge stage.
// Depends on esd_pkg, esd_front, esd_tdiv and esd_merge.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   input   | in        | in_valid / in_ready | data_word, start_of_chunk
//   result  | out       | out_valid/out_ready | kind, event_x, event_y, polarity,
//           |           |                     | event_time, last
//
// One word is taken per cycle while the 16-entry result queue has a free reservation.
// An accepted word passes one decode stage and five divide stages before the queue write;
// from the queue it moves to the serializer's current entry and then to the output register.
// The serializer gives one result per cycle while out_ready allows, so a word with n events gives n results.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
// A stalled output holds its beat; the input side keeps going until reservations run out.
`timescale 1ns / 1ps
`default_nettype none

module event_subframe_decoder_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [esd_pkg::WORD_W-1:0]  data_word,
	input  wire logic                        start_of_chunk,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             kind,
	output logic [esd_pkg::XO_W-1:0]         event_x,
	output logic [esd_pkg::YO_W-1:0]         event_y,
	output logic                             polarity,
	output logic [esd_pkg::TQ_W-1:0]         event_time,
	output logic                             last
);

	logic                      acc;
	logic                      room;
	logic                      vld_s1;
	esd_pkg::dec_t             dec_s1;
	logic [esd_pkg::TS_W-1:0]  ts_s1;
	logic                      dv_vld;
	esd_pkg::dec_t             dv_dec;
	logic [esd_pkg::TQ_W-1:0]  dv_quot;

	assign in_ready = room;
	assign acc      = in_valid && room;

	esd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.word   (data_word),
		.start  (start_of_chunk),
		.vld_s1 (vld_s1),
		.dec_s1 (dec_s1),
		.ts_s1  (ts_s1)
	);

	esd_tdiv u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_dec   (dec_s1),
		.in_ts    (ts_s1),
		.out_vld  (dv_vld),
		.out_dec  (dv_dec),
		.out_quot (dv_quot)
	);

	esd_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (acc),
		.room     (room),
		.d_vld    (dv_vld),
		.d_dec    (dv_dec),
		.d_quot   (dv_quot),
		.out_vld  (out_valid),
		.out_rdy  (out_ready),
		.out_kind (kind),
		.out_x    (event_x),
		.out_y    (event_y),
		.out_pol  (polarity),
		.out_time (event_time),
		.out_last (last)
	);

endmodule

`default_nettype wire

FILE: src/esd_check.sv
// Port-level checks for the event subframe decoder, bound to the top level.
// Depends on esd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module esd_check (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       kind,
	input wire logic [esd_pkg::XO_W-1:0]   event_x,
	input wire logic [esd_pkg::YO_W-1:0]   event_y,
	input wire logic                       polarity,
	input wire logic [esd_pkg::TQ_W-1:0]   event_time,
	input wire logic                       last
);

	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// and keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind) && $stable(event_x) && $stable(event_y)
			&& $stable(polarity) && $stable(event_time) && $stable(last))
		else $error("stalled result beat changed");

	// a header error is a lone result with empty coordinates
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> last && (event_x == '0) && (event_y == '0) && !polarity)
		else $error("malformed header error result");

	// no results once reset has been seen at an edge
	a_rst_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result beat during reset");

endmodule

bind event_subframe_decoder_core esd_check u_check (.*);

`default_nettype wire

FILE: tb/tb_event_subframe_decoder_core.sv
// Self-checking testbench for event_subframe_decoder_core: directed and random word streams.
// Depends on esd_pkg and the decoder RTL; a built-in decode model predicts every result beat.
`timescale 1ns / 1ps

module tb_event_subframe_decoder_core;

	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_ERROR   = 1'b1;
	localparam int   DRAIN_CYCLES = 64;
	localparam int   MAX_PRINTS   = 40;

	// One expected result beat
	typedef struct packed {
		logic                     kind;
		logic [esd_pkg::XO_W-1:0] x;
		logic [esd_pkg::YO_W-1:0] y;
		logic                     pol;
		logic [esd_pkg::TQ_W-1:0] tstamp;
		logic                     last;
	} ev_t;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         in_valid       = 1'b0;
	logic                         in_ready;
	logic [esd_pkg::WORD_W-1:0]   data_word      = '0;
	logic                         start_of_chunk = 1'b0;
	logic                         out_valid;
	logic                         out_ready      = 1'b0;
	logic                         kind;
	logic [esd_pkg::XO_W-1:0]     event_x;
	logic [esd_pkg::YO_W-1:0]     event_y;
	logic                         polarity;
	logic [esd_pkg::TQ_W-1:0]     event_time;
	logic                         last;

	// Decode state mirrored from the block
	esd_pkg::pos_t            dec_pos  = esd_pkg::POS_HDR;
	int unsigned              row_idx  = 0;
	int unsigned              col_word = 0;
	int unsigned              pad_done = 0;
	logic [esd_pkg::TQ_W-1:0] cur_time = '0;
	logic                     off_x    = 1'b0;
	logic                     off_y    = 1'b0;

	ev_t pending_events[$];
	int  mismatches    = 0;
	int  words_sent    = 0;
	int  beats_seen    = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;

	event_subframe_decoder_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_word      (data_word),
		.start_of_chunk (start_of_chunk),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.event_x        (event_x),
		.event_y        (event_y),
		.polarity       (polarity),
		.event_time     (event_time),
		.last           (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t ns: beat %0d: %s", $time, beats_seen, what);
	endtask

	task automatic check_field(input string name, input logic [esd_pkg::TQ_W-1:0] got,
			input logic [esd_pkg::TQ_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic ev_t make_event(input logic k, input int unsigned x,
			input int unsigned y, input logic pol);
		ev_t ev;
		ev.kind   = k;
		ev.x      = esd_pkg::XO_W'(x);
		ev.y      = esd_pkg::YO_W'(y);
		ev.pol    = pol;
		ev.tstamp = cur_time;
		ev.last   = 1'b0;
		return ev;
	endfunction

	// Advance the decode state by one word and queue the results it causes
	task automatic decode_word(input logic [esd_pkg::WORD_W-1:0] w, input logic soc);
		ev_t                        word_events[$];
		logic [esd_pkg::TS_W-1:0]   ts;
		logic [esd_pkg::IDX_W-1:0]  idx;
		logic [esd_pkg::CODE_W-1:0] code;
		int unsigned                x;
		int unsigned                y;
		if (soc) begin
			dec_pos  = esd_pkg::POS_HDR;
			row_idx  = 0;
			col_word = 0;
		end
		case (dec_pos)
			esd_pkg::POS_HDR: begin
				ts       = w[esd_pkg::TS_LSB +: esd_pkg::TS_W];
				cur_time = esd_pkg::TQ_W'(ts / esd_pkg::TIME_DIV);
				if (w[esd_pkg::SYNC_W-1:0] != esd_pkg::SYNC_PATTERN)
					word_events.insert(word_events.size(),
						make_event(KIND_ERROR, 0, 0, 1'b0));
				dec_pos = esd_pkg::POS_SUB;
			end
			esd_pkg::POS_SUB: begin
				idx      = w[esd_pkg::IDX_LSB +: esd_pkg::IDX_W];
				off_x    = (idx == esd_pkg::IDX_RIGHT || idx == esd_pkg::IDX_BOTH);
				off_y    = (idx == esd_pkg::IDX_DOWN || idx == esd_pkg::IDX_BOTH);
				row_idx  = 0;
				col_word = 0;
				dec_pos  = esd_pkg::POS_PIX;
			end
			esd_pkg::POS_PIX: begin
				y = off_y + 2 * row_idx;
				for (int k = 0; k < esd_pkg::LANES; k++) begin
					x    = off_x + 2 * (esd_pkg::LANES * col_word + k);
					code = w[esd_pkg::CODE_W*k +: esd_pkg::CODE_W];
					if (x < esd_pkg::SENSOR_WIDTH && y < esd_pkg::SENSOR_HEIGHT
							&& code != '0)
						word_events.insert(word_events.size(),
							make_event(KIND_PIXEL, x, y, code[1]));
				end
				col_word++;
				if (col_word >= esd_pkg::WPR) begin
					col_word = 0;
					row_idx++;
					if (row_idx >= esd_pkg::SUB_HEIGHT) begin
						row_idx  = 0;
						pad_done = 0;
						dec_pos  = (esd_pkg::PAD_WORDS > 0) ? esd_pkg::POS_PAD
						                                    : esd_pkg::POS_HDR;
					end
				end
			end
			default: begin
				if (pad_done + 1 >= esd_pkg::PAD_WORDS)
					dec_pos = esd_pkg::POS_HDR;
				else
					pad_done++;
			end
		endcase
		if (word_events.size() > 0)
			word_events[word_events.size()-1].last = 1'b1;
		foreach (word_events[i])
			pending_events.insert(pending_events.size(), word_events[i]);
	endtask

	// Send one beat; valid stays high afterwards unless the next call idles
	task automatic send_word(input logic [esd_pkg::WORD_W-1:0] w, input logic soc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		data_word      <= w;
		start_of_chunk <= soc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		decode_word(w, soc);
	endtask

	function automatic logic [esd_pkg::WORD_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [esd_pkg::WORD_W-1:0] header_word(
			input logic [esd_pkg::TS_W-1:0] ts, input logic [esd_pkg::SYNC_W-1:0] sync);
		return {ts, sync};
	endfunction

	function automatic logic [esd_pkg::WORD_W-1:0] index_word(
			input logic [esd_pkg::IDX_W-1:0] idx);
		logic [esd_pkg::WORD_W-1:0] w;
		w = rand64();
		w[esd_pkg::IDX_LSB +: esd_pkg::IDX_W] = idx;
		return w;
	endfunction

	// A few random lanes with random nonzero codes
	function automatic logic [esd_pkg::WORD_W-1:0] sparse_codes(input int n);
		logic [esd_pkg::WORD_W-1:0] w;
		w = '0;
		repeat (n)
			w[esd_pkg::CODE_W*$urandom_range(esd_pkg::LANES-1) +: esd_pkg::CODE_W] =
				esd_pkg::CODE_W'($urandom_range(1, 3));
		return w;
	endfunction

	function automatic logic [esd_pkg::WORD_W-1:0] pixel_payload();
		case ($urandom_range(9))
			0, 1, 2, 3: return '0;
			4, 5, 6:    return sparse_codes($urandom_range(1, 4));
			7, 8:       return rand64();
			default:    return '1;
		endcase
	endfunction

	// Sync check and timestamp scaling at the extremes
	task automatic test_header_checks();
		send_word(header_word('1, esd_pkg::SYNC_PATTERN), 1'b1);
		send_word(index_word('0), 1'b0);
		send_word('1, 1'b0);
		send_word(header_word('0, '0), 1'b1);
		send_word(header_word(esd_pkg::TS_W'(199), 24'hFFFFFF), 1'b1);
		send_word(header_word(esd_pkg::TS_W'(200), esd_pkg::SYNC_PATTERN ^ 24'h010000), 1'b1);
		send_word(index_word('0), 1'b0);
		send_word(sparse_codes(2), 1'b0);
		send_word(header_word(esd_pkg::TS_W'(399), esd_pkg::SYNC_PATTERN), 1'b1);
	endtask

	// Each offset selection, plus an out-of-range index, with distinct pixel codes
	task automatic test_subframe_index();
		logic [esd_pkg::IDX_W-1:0]  idx_list[4];
		logic [esd_pkg::WORD_W-1:0] pix_list[4];
		idx_list = '{esd_pkg::IDX_RIGHT, esd_pkg::IDX_DOWN, esd_pkg::IDX_BOTH, 4'hF};
		pix_list = '{{esd_pkg::LANES{2'b01}}, {esd_pkg::LANES{2'b10}}, rand64(),
			{esd_pkg::LANES/2{4'h9}}};
		for (int i = 0; i < 4; i++) begin
			send_word(header_word(esd_pkg::TS_W'(rand64()), esd_pkg::SYNC_PATTERN), 1'b1);
			send_word(index_word(idx_list[i]), 1'b0);
			send_word(pix_list[i], 1'b0);
		end
	endtask

	// Chunk start in the middle of a row clears the counters
	task automatic test_chunk_restart();
		send_word(header_word(esd_pkg::TS_W'(rand64()), esd_pkg::SYNC_PATTERN), 1'b1);
		send_word(index_word(esd_pkg::IDX_BOTH), 1'b0);
		send_word('0, 1'b0);
		send_word('0, 1'b0);
		send_word('1, 1'b1);
		send_word(index_word(esd_pkg::IDX_DOWN), 1'b0);
		send_word({esd_pkg::LANES{2'b11}}, 1'b0);
	endtask

	// Two whole rows and the start of a third; full words sit at each row edge
	task automatic test_row_advance();
		logic [esd_pkg::WORD_W-1:0] w;
		int                         c_in_row;
		send_word(header_word(esd_pkg::TS_W'(rand64()), esd_pkg::SYNC_PATTERN), 1'b1);
		send_word(index_word(esd_pkg::IDX_BOTH), 1'b0);
		for (int c = 0; c < 2 * esd_pkg::WPR + 2; c++) begin
			c_in_row = c % esd_pkg::WPR;
			if (c_in_row == 0 || c_in_row == esd_pkg::WPR - 1)
				w = '1;
			else if ($urandom_range(99) < 20)
				w = sparse_codes(1);
			else
				w = '0;
			send_word(w, 1'b0);
		end
		send_word(header_word(esd_pkg::TS_W'(rand64()), esd_pkg::SYNC_PATTERN), 1'b1);
	endtask

	// Mostly well-formed subframe starts with random content, some noise words
	task automatic test_random_traffic(input int n_words);
		int                         first_word;
		int                         n_pix;
		logic [esd_pkg::SYNC_W-1:0] sync;
		logic [esd_pkg::TS_W-1:0]   ts;
		logic [esd_pkg::IDX_W-1:0]  idx;
		first_word = words_sent;
		while (words_sent - first_word < n_words) begin
			if ($urandom_range(99) < 80) begin
				sync = esd_pkg::SYNC_PATTERN;
				if ($urandom_range(99) < 15)
					sync = $urandom_range(1) ? esd_pkg::SYNC_W'($urandom)
						: esd_pkg::SYNC_PATTERN
						^ (esd_pkg::SYNC_W'(1) << $urandom_range(esd_pkg::SYNC_W - 1));
				case ($urandom_range(9))
					0:       ts = '1;
					1:       ts = '0;
					2:       ts = esd_pkg::TS_W'(esd_pkg::TIME_DIV * $urandom_range(1000)
					              + $urandom_range(1));
					default: ts = esd_pkg::TS_W'(rand64());
				endcase
				send_word(header_word(ts, sync), $urandom_range(99) < 90);
				idx = ($urandom_range(99) < 80) ? esd_pkg::IDX_W'($urandom_range(3))
				                                : esd_pkg::IDX_W'($urandom);
				send_word(index_word(idx), 1'b0);
				n_pix = $urandom_range(45);
				repeat (n_pix)
					send_word(pixel_payload(), $urandom_range(99) < 2);
			end else begin
				send_word(rand64(), $urandom_range(1));
			end
		end
	endtask

	// Result side: random back-pressure and in-order compare
	always @(posedge clk) begin : result_check
		ev_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("result beat with nothing pending");
			end else begin
				want = pending_events.pop_front();
				check_field("kind", kind, want.kind);
				check_field("event_x", event_x, want.x);
				check_field("event_y", event_y, want.y);
				check_field("polarity", polarity, want.pol);
				check_field("event_time", event_time, want.tstamp);
				check_field("last", last, want.last);
			end
			beats_seen++;
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 73;
		test_header_checks();
		test_subframe_index();
		test_chunk_restart();
		test_random_traffic(40);

		send_idle_pct = 73;
		recv_idle_pct = 37;
		test_random_traffic(40);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_row_advance();
		test_random_traffic(40);

		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
